// ===== hw/rtl/pal_pkg.sv =====
// Shared constants and codes for the positional array list.
`default_nettype none

package pal_pkg;

	// Store capacity, the address width derived from it, and the field widths.
	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = 11;
	localparam int OPW   = 2;
	localparam int STW   = 2;
	localparam int DW    = 32;

	// Operation codes.
	localparam logic [OPW-1:0] OP_INSERT = 2'd0;
	localparam logic [OPW-1:0] OP_DELETE = 2'd1;
	localparam logic [OPW-1:0] OP_READ   = 2'd2;

	// Status codes.
	localparam logic [STW-1:0] ST_DONE  = 2'd0;
	localparam logic [STW-1:0] ST_RANGE = 2'd1;
	localparam logic [STW-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/pal_req_if.sv =====
// Request channel interface: one word is one list operation.
`default_nettype none

interface pal_req_if
	import pal_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [OPW-1:0]       operation;
	logic [LW-1:0]        position;
	logic [LW-1:0]        count;
	logic signed [DW-1:0] value;

	modport source (output valid, output operation, output position, output count,
		output value, input ready);
	modport sink (input valid, input operation, input position, input count,
		input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pal_rsp_if.sv =====
// Response channel interface: one word is the result of one operation.
`default_nettype none

interface pal_rsp_if
	import pal_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [STW-1:0]       status;
	logic [LW-1:0]        list_length;
	logic signed [DW-1:0] read_data;

	modport source (output valid, output status, output list_length, output read_data,
		input ready);
	modport sink (input valid, input status, input list_length, input read_data,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/positional_array_list.sv =====
// Positional array list: an ordered list of signed words kept in one memory.
// The block takes one request word at a time and returns exactly one response
// word for it. A read or a rejected request goes from decode straight to the
// result state. An insert or delete moves the tail through the single memory,
// one entry per cycle (read one entry, write it in the next cycle one slot up
// for an insert, or down by the number of deleted entries for a delete). An
// insert steps through decode, shift, drain, value write and result, and skips
// shift and drain when nothing moves. A delete steps through decode, shift,
// drain and result, and skips shift and drain when nothing moves. The block is
// ready for the next request word once the response appears, or later while an
// earlier response still waits to be taken. At most 1023 entries move, as in an
// insert at the head of a list of 1023 entries.
// The memory needs no clearing after reset: only entries below the current
// length are ever read.
`default_nettype none

module positional_array_list
	import pal_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	pal_req_if.sink   req,
	pal_rsp_if.source rsp
);

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_PUTVAL = 3'd4;
	localparam logic [2:0] S_RESULT = 3'd5;

	logic [2:0]           state_q;
	logic [LW-1:0]        len_q;
	logic [OPW-1:0]       op_q;
	logic [LW-1:0]        pos_q;
	logic [LW-1:0]        cnt_q;
	logic [DW-1:0]        val_q;
	logic [STW-1:0]       status_q;
	logic                 rd_ok_q;
	logic                 up_q;
	logic [AW-1:0]        rd_idx_q;
	logic [AW-1:0]        end_idx_q;
	logic [AW-1:0]        at_q;
	logic [LW-1:0]        shift_q;

	// Pending shift write, carried out in the cycle after its read.
	logic                 pend_s1;
	logic [AW-1:0]        pend_addr_s1;

	// List storage.
	logic [DW-1:0]        mem [DEPTH];
	logic [DW-1:0]        mem_rd_q;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [DW-1:0]        mem_wdata;

	// Decode terms.
	logic [LW-1:0]        at_full;
	logic                 pos_nz;
	logic                 ins_pos_ok;
	logic                 acc_pos_ok;
	logic [LW-1:0]        avail;
	logic [LW-1:0]        del_n;
	logic                 del_shift;
	logic                 ins_shift;
	logic                 out_free;

	assign at_full    = pos_q - LW'(1);
	assign pos_nz     = (pos_q != '0);
	assign ins_pos_ok = pos_nz && ({1'b0, pos_q} <= ({1'b0, len_q} + (LW + 1)'(1)));
	assign acc_pos_ok = pos_nz && (pos_q <= len_q);
	assign avail      = len_q - at_full;
	assign del_n      = (cnt_q < avail) ? cnt_q : avail;
	assign del_shift  = (del_n != '0) && (({1'b0, at_full} + {1'b0, del_n}) < {1'b0, len_q});
	assign ins_shift  = (len_q > at_full);
	assign out_free   = !rsp.valid || rsp.ready;

	assign req.ready = (state_q == S_IDLE);

	// Memory port selection.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = rd_idx_q;
		if (state_q == S_SHIFT) begin
			mem_re = 1'b1;
		end else if (state_q == S_DECODE && op_q == OP_READ && acc_pos_ok) begin
			mem_re    = 1'b1;
			mem_raddr = at_full[AW-1:0];
		end
		mem_we    = pend_s1 || (state_q == S_PUTVAL);
		mem_waddr = pend_s1 ? pend_addr_s1 : at_q;
		mem_wdata = pend_s1 ? mem_rd_q : val_q;
	end

	// Synchronous memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_raddr];
		end
	end

	// Latch the request word on acceptance.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.operation;
			pos_q <= req.position;
			cnt_q <= req.count;
			val_q <= req.value;
		end
	end

	// Sequencer and list length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			status_q     <= ST_RANGE;
			rd_ok_q      <= 1'b0;
			up_q         <= 1'b0;
			rd_idx_q     <= '0;
			end_idx_q    <= '0;
			at_q         <= '0;
			shift_q      <= '0;
			pend_s1      <= 1'b0;
			pend_addr_s1 <= '0;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					status_q <= ST_RANGE;
					rd_ok_q  <= 1'b0;
					at_q     <= at_full[AW-1:0];
					state_q  <= S_RESULT;
					case (op_q)
						OP_INSERT: begin
							if (ins_pos_ok) begin
								if (len_q == LW'(DEPTH)) begin
									status_q <= ST_FULL;
								end else begin
									status_q  <= ST_DONE;
									len_q     <= len_q + LW'(1);
									up_q      <= 1'b1;
									rd_idx_q  <= AW'(len_q - LW'(1));
									end_idx_q <= at_full[AW-1:0];
									state_q   <= ins_shift ? S_SHIFT : S_PUTVAL;
								end
							end
						end
						OP_DELETE: begin
							if (acc_pos_ok) begin
								status_q  <= ST_DONE;
								len_q     <= len_q - del_n;
								up_q      <= 1'b0;
								shift_q   <= del_n;
								rd_idx_q  <= AW'(at_full + del_n);
								end_idx_q <= AW'(len_q - LW'(1));
								if (del_shift) begin
									state_q <= S_SHIFT;
								end
							end
						end
						OP_READ: begin
							if (acc_pos_ok) begin
								status_q <= ST_DONE;
								rd_ok_q  <= 1'b1;
							end
						end
						default: begin
							status_q <= ST_RANGE;
						end
					endcase
				end
				S_SHIFT: begin
					// Read one tail entry; it is written back in the next cycle.
					pend_s1      <= 1'b1;
					pend_addr_s1 <= up_q ? (rd_idx_q + AW'(1)) : (rd_idx_q - shift_q[AW-1:0]);
					if (rd_idx_q == end_idx_q) begin
						state_q <= S_DRAIN;
					end else begin
						rd_idx_q <= up_q ? (rd_idx_q - AW'(1)) : (rd_idx_q + AW'(1));
					end
				end
				S_DRAIN: begin
					state_q <= up_q ? S_PUTVAL : S_RESULT;
				end
				S_PUTVAL: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register for the response word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			rsp.status      <= status_q;
			rsp.list_length <= len_q;
			rsp.read_data   <= rd_ok_q ? mem_rd_q : '0;
		end
	end

endmodule

`default_nettype wire
